### sv/nce_pkg.sv
// nce_pkg: shared types, constants and the squared-distance function
// for the nearest-corner endpoint tracker. No dependencies.
package nce_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned CORNERS    = 4;
  localparam int unsigned CORNER_W   = $clog2(CORNERS);
  localparam int unsigned BOUND_W    = 2 * (COORD_BITS + 1);
  localparam int unsigned CFG_IDX_W  = 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [BOUND_W-1:0]    bound_t;
  typedef logic [CORNER_W-1:0]   corner_idx_t;

  localparam coord_t COLS_RESET = coord_t'(640);
  localparam coord_t ROWS_RESET = coord_t'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COLS = 1'b0,
    CFG_IMAGE_ROWS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    logic   last_segment;
  } in_word_t;

  typedef struct packed {
    coord_t top_left_x;
    coord_t top_left_y;
    coord_t top_right_x;
    coord_t top_right_y;
    coord_t bottom_left_x;
    coord_t bottom_left_y;
    coord_t bottom_right_x;
    coord_t bottom_right_y;
  } out_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef point_t [CORNERS-1:0] result_t;

  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    logic   take;
    logic   last;
  } seg_t;

  function automatic bound_t sq_dist(coord_t px, coord_t py, coord_t cx, coord_t cy);
    coord_t                    dx;
    coord_t                    dy;
    logic [2*COORD_BITS-1:0] sx;
    logic [2*COORD_BITS-1:0] sy;
    dx = (px >= cx) ? (px - cx) : (cx - px);
    dy = (py >= cy) ? (py - cy) : (cy - py);
    sx = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
    sy = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
    return BOUND_W'(sx) + BOUND_W'(sy);
  endfunction

endpackage

### sv/nearest_corner_endpoints.sv
// nearest_corner_endpoints: top level, config registers, chain of four
// corner cells and the output register. Depends on nce_pkg and nce_cell.
//
// Takes one segment word per clock while in_stall_o is low. The word runs down
// a chain of four corner cells (top-left, top-right, bottom-left, bottom-right),
// two register stages per cell, and a word flagged last_segment delivers its
// result word into the output register; other words give no result. A segment
// with any zero coordinate changes no corner. in_stall_o rises only while a
// result waits in the output register under out_stall_i and the next
// last-flagged word has reached the end of the chain. The config port is
// always ready; write image_cols/image_rows only while idle.
module nearest_corner_endpoints (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nce_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nce_pkg::out_word_t            out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nce_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  nce_pkg::coord_t               cfg_data_i
);

  nce_pkg::coord_t    cols_q;
  nce_pkg::coord_t    rows_q;
  nce_pkg::bound_t    init_bound_q;
  logic [nce_pkg::COORD_BITS:0] dim_sum;

  logic               chain_valid [nce_pkg::CORNERS+1];
  nce_pkg::seg_t      chain_seg   [nce_pkg::CORNERS+1];
  nce_pkg::result_t   chain_res   [nce_pkg::CORNERS+1];

  logic               en;
  logic               tail_done;
  logic               out_valid_q;
  nce_pkg::out_word_t out_word_q;
  nce_pkg::result_t   tail_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= nce_pkg::COLS_RESET;
      rows_q <= nce_pkg::ROWS_RESET;
    end else if (cfg_valid_i) begin
      case (nce_pkg::cfg_idx_e'(cfg_index_i))
        nce_pkg::CFG_IMAGE_COLS: cols_q <= cfg_data_i;
        nce_pkg::CFG_IMAGE_ROWS: rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dim_sum = {1'b0, cols_q} + {1'b0, rows_q};

  always_ff @(posedge clk_i) begin
    init_bound_q <= nce_pkg::bound_t'(dim_sum) * nce_pkg::bound_t'(dim_sum);
  end

  assign tail_done  = chain_valid[nce_pkg::CORNERS] && chain_seg[nce_pkg::CORNERS].last;
  assign en         = !(out_valid_q && out_stall_i && tail_done);
  assign in_stall_o = !en;

  assign chain_valid[0]    = in_valid_i;
  assign chain_seg[0].p1x  = in_word_i.first_x;
  assign chain_seg[0].p1y  = in_word_i.first_y;
  assign chain_seg[0].p2x  = in_word_i.second_x;
  assign chain_seg[0].p2y  = in_word_i.second_y;
  assign chain_seg[0].take = (|in_word_i.first_x) && (|in_word_i.first_y) &&
                             (|in_word_i.second_x) && (|in_word_i.second_y);
  assign chain_seg[0].last = in_word_i.last_segment;
  assign chain_res[0]      = '0;

  for (genvar g = 0; g < nce_pkg::CORNERS; g++) begin : g_cell
    nce_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .idx_i        (nce_pkg::corner_idx_t'(g)),
      .cols_i       (cols_q),
      .rows_i       (rows_q),
      .init_bound_i (init_bound_q),
      .valid_i      (chain_valid[g]),
      .seg_i        (chain_seg[g]),
      .res_i        (chain_res[g]),
      .valid_o      (chain_valid[g+1]),
      .seg_o        (chain_seg[g+1]),
      .res_o        (chain_res[g+1])
    );
  end

  assign tail_res = chain_res[nce_pkg::CORNERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= tail_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_word_q.top_left_x     <= tail_res[0].x;
      out_word_q.top_left_y     <= tail_res[0].y;
      out_word_q.top_right_x    <= tail_res[1].x;
      out_word_q.top_right_y    <= tail_res[1].y;
      out_word_q.bottom_left_x  <= tail_res[2].x;
      out_word_q.bottom_left_y  <= tail_res[2].y;
      out_word_q.bottom_right_x <= tail_res[3].x;
      out_word_q.bottom_right_y <= tail_res[3].y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### sv/nce_cell.sv
// nce_cell: one corner of the tracker, two stages (distances, then compare)
// holding that corner's kept point. Depends on nce_pkg.
module nce_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  nce_pkg::corner_idx_t idx_i,
  input  nce_pkg::coord_t      cols_i,
  input  nce_pkg::coord_t      rows_i,
  input  nce_pkg::bound_t      init_bound_i,
  input  logic                 valid_i,
  input  nce_pkg::seg_t        seg_i,
  input  nce_pkg::result_t     res_i,
  output logic                 valid_o,
  output nce_pkg::seg_t        seg_o,
  output nce_pkg::result_t     res_o
);

  nce_pkg::coord_t  cx;
  nce_pkg::coord_t  cy;

  logic             a_valid_q;
  nce_pkg::seg_t    a_seg_q;
  nce_pkg::result_t a_res_q;
  nce_pkg::bound_t  a_d1_q;
  nce_pkg::bound_t  a_d2_q;

  logic             held_q, held_d;
  nce_pkg::point_t  best_q, best_d;
  nce_pkg::bound_t  bound_q, bound_d;

  logic             b_valid_q;
  nce_pkg::seg_t    b_seg_q;
  nce_pkg::result_t b_res_q, b_res_d;

  nce_pkg::bound_t  bound_eff;
  nce_pkg::bound_t  bound_mid;
  nce_pkg::point_t  pt_mid;
  nce_pkg::point_t  pt_new;
  nce_pkg::bound_t  bound_new;
  logic             hit1, hit2;

  assign cx = idx_i[0] ? cols_i : '0;
  assign cy = idx_i[nce_pkg::CORNER_W-1] ? rows_i : '0;

  // distance stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_seg_q <= seg_i;
      a_res_q <= res_i;
      a_d1_q  <= nce_pkg::sq_dist(seg_i.p1x, seg_i.p1y, cx, cy);
      a_d2_q  <= nce_pkg::sq_dist(seg_i.p2x, seg_i.p2y, cx, cy);
    end
  end

  // compare stage: first endpoint, then second against the updated bound
  always_comb begin
    bound_eff = held_q ? bound_q : init_bound_i;
    hit1      = a_seg_q.take && (a_d1_q < bound_eff);
    bound_mid = hit1 ? a_d1_q : bound_eff;
    pt_mid    = hit1 ? nce_pkg::point_t'{x: a_seg_q.p1x, y: a_seg_q.p1y} : best_q;
    hit2      = a_seg_q.take && (a_d2_q < bound_mid);
    bound_new = hit2 ? a_d2_q : bound_mid;
    pt_new    = hit2 ? nce_pkg::point_t'{x: a_seg_q.p2x, y: a_seg_q.p2y} : pt_mid;

    b_res_d   = a_res_q;
    held_d    = held_q;
    best_d    = best_q;
    bound_d   = bound_q;
    if (a_valid_q) begin
      if (a_seg_q.last) begin
        b_res_d[idx_i] = pt_new;
        held_d         = 1'b0;
        best_d         = '0;
        bound_d        = bound_new;
      end else begin
        held_d  = held_q | hit1 | hit2;
        best_d  = pt_new;
        bound_d = bound_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      held_q    <= 1'b0;
      best_q    <= '0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
      held_q    <= held_d;
      best_q    <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bound_q <= bound_d;
      b_seg_q <= a_seg_q;
      b_res_q <= b_res_d;
    end
  end

  assign valid_o = b_valid_q;
  assign seg_o   = b_seg_q;
  assign res_o   = b_res_q;

endmodule

### sv/nce_checker.sv
// nce_checker: port-level assertions for nearest_corner_endpoints, bound
// to the top level. Depends on nce_pkg.
module nce_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input nce_pkg::in_word_t             in_word_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input nce_pkg::out_word_t            out_word_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed under stall");

  // stalled segment word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("segment word changed under stall");

  // input is held off only by a blocked result
  a_stall_cause: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word right after reset");

  // a kept point never has a zero coordinate, a missing one is all zero
  a_point_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_word_o.top_left_x == '0) == (out_word_o.top_left_y == '0)) &&
      ((out_word_o.top_right_x == '0) == (out_word_o.top_right_y == '0)) &&
      ((out_word_o.bottom_left_x == '0) == (out_word_o.bottom_left_y == '0)) &&
      ((out_word_o.bottom_right_x == '0) == (out_word_o.bottom_right_y == '0)))
    else $error("corner point with exactly one zero coordinate");

endmodule

bind nearest_corner_endpoints nce_checker u_nce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
